FILE: rtl/erm_pkg.sv
// Package for the elliptic region mask table: sizes, codes, row and span types.
// Used by erm_in_if, erm_span, the core and the testbench; depends on nothing.
package erm_pkg;

    localparam int MAX_ROWS   = 512;
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;
    localparam int W_BITS     = COORD_BITS + 1;
    localparam int H_BITS     = 10;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int Q_BITS     = FRAC_BITS + 1;
    localparam int V_BITS     = 2 * FRAC_BITS + 1;
    localparam int X_BITS     = COORD_BITS + FRAC_BITS;
    localparam int ROW_W      = 4 * COORD_BITS;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = W_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd360;
    localparam logic [H_BITS-1:0] IMAGE_HEIGHT_RST = 10'd290;

    localparam logic [1:0] OP_OUTER    = 2'd0;
    localparam logic [1:0] OP_INNER    = 2'd1;
    localparam logic [1:0] OP_DEFAULTS = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] li;
        logic [COORD_BITS-1:0] ri;
        logic [COORD_BITS-1:0] ro;
    } t_row;

    typedef struct packed {
        logic                  start;
        logic [ROW_BITS-1:0]   row;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [W_BITS-1:0]     w;
    } t_span_req;

    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] x2;
    } t_span_rsp;

endpackage

FILE: rtl/erm_in_if.sv
// Input channel of the mask table: valid/ready and the operation fields.
// Depends on erm_pkg.
interface erm_in_if;
    import erm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            op;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] semi_a;
    logic [COORD_BITS-1:0] semi_b;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (output valid, op, center_x, center_y, semi_a, semi_b, point_x, point_y,
                    input ready);
    modport sink (input valid, op, center_x, center_y, semi_a, semi_b, point_x, point_y,
                  output ready);
endinterface

FILE: rtl/erm_out_if.sv
// Result channel of the mask table: valid/ready and the query flags.
// Depends on nothing.
interface erm_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic in_outer;
    logic in_hole;
    logic done_res;

    modport source (output valid, inside_res, in_outer, in_hole, done_res, input ready);
    modport sink (input valid, inside_res, in_outer, in_hole, done_res, output ready);
endinterface

FILE: rtl/erm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module erm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/erm_span.sv
// Span unit: left and right ellipse edge on one row, by a bit-serial divide,
// a bit-serial square root and one multiply. Depends on erm_pkg.
module erm_span (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  erm_pkg::t_span_req  i_req,
    output erm_pkg::t_span_rsp  o_rsp
);
    import erm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQR   = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_RINIT = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    localparam logic [4:0] DIV_LAST  = 5'(FRAC_BITS - 1);
    localparam logic [4:0] ROOT_LAST = 5'(FRAC_BITS);

    logic [2:0]           r_st;
    logic [4:0]           r_cnt;
    logic [SQ_BITS-1:0]   r_dd;
    logic [SQ_BITS-1:0]   r_bb;
    logic [SQ_BITS-1:0]   r_rem;
    logic [FRAC_BITS-1:0] r_quo;
    logic [V_BITS-1:0]    r_v;
    logic [V_BITS-1:0]    r_res;
    logic [V_BITS-1:0]    r_bit;
    logic                 r_outside;
    logic [X_BITS:0]      r_x;

    logic [COORD_BITS-1:0]         row_ext;
    logic [COORD_BITS-1:0]         abs_d;
    logic [SQ_BITS:0]              rem2;
    logic                          div_ge;
    logic [V_BITS:0]               root_sum;
    logic                          root_ge;
    logic [Q_BITS-1:0]             s_val;
    logic [COORD_BITS+Q_BITS-1:0]  mul_p;
    logic [X_BITS+1:0]             cfix;
    logic [X_BITS+1:0]             xs;
    logic [X_BITS+1:0]             lfix;
    logic [X_BITS+1:0]             rfix;
    logic [X_BITS+1:0]             wlim;
    logic [W_BITS-1:0]             w_m1;
    logic [W_BITS-1:0]             w_m2;
    logic                          l_small;
    logic                          r_big;

    always_comb begin
        row_ext  = COORD_BITS'(i_req.row);
        abs_d    = (row_ext >= i_req.cy) ? row_ext - i_req.cy : i_req.cy - row_ext;
        rem2     = {r_rem, 1'b0};
        div_ge   = rem2 >= {1'b0, r_bb};
        root_sum = {1'b0, r_res} + {1'b0, r_bit};
        root_ge  = {1'b0, r_v} >= root_sum;
        s_val    = Q_BITS'(1 << FRAC_BITS) - {1'b0, r_quo};
        mul_p    = i_req.a * r_res[Q_BITS-1:0];
        cfix     = {2'b00, i_req.cx, FRAC_BITS'(0)};
        xs       = {1'b0, r_x};
        lfix     = cfix - xs;
        rfix     = cfix + xs;
        w_m1     = i_req.w - W_BITS'(1);
        w_m2     = i_req.w - W_BITS'(2);
        wlim     = {1'b0, w_m1, FRAC_BITS'(0)};
        l_small  = cfix < (xs + (X_BITS+2)'(1 << FRAC_BITS));
        r_big    = rfix >= wlim;
    end

    always_comb begin
        o_rsp.done = (r_st == S_FIN);
        if (r_outside) begin
            o_rsp.x1 = i_req.cx;
            o_rsp.x2 = i_req.cx;
        end else begin
            o_rsp.x1 = l_small ? COORD_BITS'(1) : lfix[X_BITS-1:FRAC_BITS];
            o_rsp.x2 = r_big ? w_m2[COORD_BITS-1:0]
                             : i_req.cx + r_x[X_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_st <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_dd <= abs_d * abs_d;
                    r_bb <= i_req.b * i_req.b;
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    r_outside <= (r_dd >= r_bb);
                    r_rem     <= r_dd;
                    r_cnt     <= '0;
                    r_st      <= (r_dd >= r_bb) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    // one quotient bit a step; remainder stays below the divisor
                    r_rem <= div_ge ? SQ_BITS'(rem2 - {1'b0, r_bb}) : rem2[SQ_BITS-1:0];
                    r_quo <= {r_quo[FRAC_BITS-2:0], div_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_st <= S_RINIT;
                    end
                end
                S_RINIT: begin
                    r_v   <= {s_val, FRAC_BITS'(0)};
                    r_res <= '0;
                    r_bit <= V_BITS'(1) << (2 * FRAC_BITS);
                    r_cnt <= '0;
                    r_st  <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_ge) begin
                        r_v   <= r_v - root_sum[V_BITS-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == ROOT_LAST) begin
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_x  <= (X_BITS+1)'(mul_p) + (X_BITS+1)'(1 << (FRAC_BITS - 1));
                    r_st <= S_FIN;
                end
                S_FIN: begin
                    r_st <= S_IDLE;
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: rtl/elliptic_region_mask_table_core.sv
// Elliptic region mask table: a 512-row table of outer span and inner hole,
// held in one RAM, read-modified-written one row at a time. After reset a
// clearing pass writes zeros to all 512 rows before the first transaction
// is taken; configuration writes are taken at any time. A query does one RAM
// read, none when its row lies at or beyond the height. Reset defaults write
// every row below the height. An apply first scans the table, then reads
// each row in use and clears it, leaves it alone, or has the span unit work
// out its edges (8-step divide, 9-step square root, one multiply; all three
// are skipped when the row falls outside the ellipse) and writes it back.
// Zero semi-axes or no rows in use skip the scan and the rows. A stalled
// result holds the block.
module elliptic_region_mask_table_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [erm_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [erm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    erm_in_if.sink                             i_req,
    erm_out_if.source                          o_rsp
);
    import erm_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_QRD   = 4'd2;
    localparam logic [3:0] ST_QEV   = 4'd3;
    localparam logic [3:0] ST_DEF   = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_PRD   = 4'd6;
    localparam logic [3:0] ST_PEV   = 4'd7;
    localparam logic [3:0] ST_PSPAN = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    localparam logic [H_BITS-1:0] LAST_ROW = H_BITS'(MAX_ROWS - 1);

    logic [3:0]            r_st;
    logic [W_BITS-1:0]     r_img_w;
    logic [H_BITS-1:0]     r_img_h;
    logic [H_BITS-1:0]     r_idx;
    logic [1:0]            r_op;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [COORD_BITS-1:0] r_a;
    logic [COORD_BITS-1:0] r_b;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [COORD_BITS-1:0] r_top;
    logic [ROW_BITS-1:0]   r_bot;
    logic                  r_found;
    logic                  r_have_old;
    logic [ROW_BITS-1:0]   r_old_top;
    logic [ROW_BITS-1:0]   r_old_bot;
    logic                  r_sv;
    logic [ROW_BITS-1:0]   r_srow;
    t_row                  r_row;
    logic                  r_res_inside;
    logic                  r_res_outer;
    logic                  r_res_hole;
    logic                  r_out_valid;
    logic                  r_out_inside;
    logic                  r_out_outer;
    logic                  r_out_hole;

    logic [W_BITS-1:0]     eff_w;
    logic [H_BITS-1:0]     eff_h;
    logic [H_BITS-1:0]     h_last;
    logic                  last_row;
    logic [COORD_BITS:0]   cy_b_sum;
    logic [ROW_BITS-1:0]   acc_bot;
    logic [COORD_BITS-1:0] acc_top;
    logic                  ram_we;
    logic [ROW_BITS-1:0]   ram_raddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic [ROW_W-1:0]      ram_rdata;
    t_row                  rd;
    t_row                  wr;
    logic [COORD_BITS-1:0] u_top;
    logic [COORD_BITS-1:0] u_bot;
    logic [COORD_BITS-1:0] bot_ext;
    logic                  zero_cls;
    logic                  span_cls;
    logic [W_BITS-1:0]     w_m1;
    logic [W_BITS-1:0]     w_m2;
    logic [COORD_BITS-1:0] ro_eff;
    logic [COORD_BITS-1:0] lo_n;
    logic [COORD_BITS-1:0] ro_n;
    logic [COORD_BITS-1:0] li_n;
    logic [COORD_BITS-1:0] ri_n;
    logic                  q_outer;
    logic                  q_hole;
    t_span_req             span_req;
    t_span_rsp             span_rsp;

    erm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[ROW_BITS-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    erm_span u_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (span_req),
        .o_rsp   (span_rsp)
    );

    always_comb begin
        if (r_img_w < W_BITS'(3)) begin
            eff_w = W_BITS'(3);
        end else if (r_img_w > W_BITS'(1 << COORD_BITS)) begin
            eff_w = W_BITS'(1 << COORD_BITS);
        end else begin
            eff_w = r_img_w;
        end
        eff_h    = (r_img_h > H_BITS'(MAX_ROWS)) ? H_BITS'(MAX_ROWS) : r_img_h;
        h_last   = eff_h - H_BITS'(1);
        last_row = (r_idx == h_last);
        w_m1     = eff_w - W_BITS'(1);
        w_m2     = eff_w - W_BITS'(2);

        cy_b_sum = {1'b0, i_req.center_y} + {1'b0, i_req.semi_b};
        acc_top  = (i_req.center_y > i_req.semi_b) ? i_req.center_y - i_req.semi_b : '0;
        acc_bot  = (cy_b_sum > (COORD_BITS+1)'(h_last)) ? h_last[ROW_BITS-1:0]
                                                         : cy_b_sum[ROW_BITS-1:0];

        rd      = t_row'(ram_rdata);
        bot_ext = COORD_BITS'(r_bot);

        // union of the old hole rows and the new ellipse rows
        u_top = r_top;
        u_bot = bot_ext;
        if (r_have_old) begin
            if (COORD_BITS'(r_old_top) < r_top) begin
                u_top = COORD_BITS'(r_old_top);
            end
            if (COORD_BITS'(r_old_bot) > bot_ext) begin
                u_bot = COORD_BITS'(r_old_bot);
            end
        end

        if (r_op == OP_OUTER) begin
            zero_cls = (r_idx <= r_top) || (r_idx > bot_ext);
            span_cls = !zero_cls;
        end else begin
            zero_cls = (r_idx < u_top) || (r_idx > u_bot);
            span_cls = !zero_cls && (r_idx >= r_top) && (r_idx <= bot_ext);
        end

        ro_eff = r_found ? r_row.ro : w_m1[COORD_BITS-1:0];
        lo_n   = (r_row.lo < span_rsp.x1 && ro_eff > span_rsp.x1) ? span_rsp.x1 : r_row.lo;
        ro_n   = (ro_eff > span_rsp.x2 && span_rsp.x2 > lo_n) ? span_rsp.x2 : ro_eff;
        li_n   = (span_rsp.x1 >= r_row.lo && span_rsp.x1 < r_row.ro &&
                  (r_row.li == '0 || span_rsp.x1 < r_row.li)) ? span_rsp.x1 : r_row.li;
        ri_n   = (span_rsp.x2 <= r_row.ro &&
                  (r_row.ri == '0 || span_rsp.x2 > r_row.ri)) ? span_rsp.x2 : r_row.ri;

        q_outer = (r_px >= rd.lo) && (r_px <= rd.ro);
        q_hole  = (r_px > rd.li) && (r_px < rd.ri);
    end

    always_comb begin
        ram_raddr = (r_st == ST_QRD) ? r_py[ROW_BITS-1:0] : r_idx[ROW_BITS-1:0];
        ram_we    = 1'b0;
        wr        = '0;
        case (r_st)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_DEF: begin
                ram_we = 1'b1;
                wr.lo  = COORD_BITS'(1);
                wr.ro  = w_m2[COORD_BITS-1:0];
            end
            ST_PEV: begin
                ram_we = zero_cls;
                wr     = rd;
                if (r_op == OP_OUTER) begin
                    wr.lo = '0;
                    wr.ro = '0;
                end else begin
                    wr.li = '0;
                    wr.ri = '0;
                end
            end
            ST_PSPAN: begin
                ram_we = span_rsp.done;
                wr     = r_row;
                if (r_op == OP_OUTER) begin
                    wr.lo = lo_n;
                    wr.ro = ro_n;
                end else begin
                    wr.li = li_n;
                    wr.ri = ri_n;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        ram_wdata = wr;
    end

    always_comb begin
        span_req.start = (r_st == ST_PEV) && span_cls;
        span_req.row   = r_idx[ROW_BITS-1:0];
        span_req.cx    = r_cx;
        span_req.cy    = r_cy;
        span_req.a     = r_a;
        span_req.b     = r_b;
        span_req.w     = eff_w;
    end

    assign i_req.ready      = (r_st == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.inside_res = r_out_inside;
    assign o_rsp.in_outer   = r_out_outer;
    assign o_rsp.in_hole    = r_out_hole;
    assign o_rsp.done_res   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMAGE_WIDTH_RST;
            r_img_h <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[H_BITS-1:0];
                default: begin
                    r_img_w <= r_img_w;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_sv        <= 1'b0;
            r_found     <= 1'b0;
            r_have_old  <= 1'b0;
        end else begin
            // the finishing state loads the result register itself
            if (r_out_valid && o_rsp.ready && r_st != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                ST_CLEAR: begin
                    if (r_idx == LAST_ROW) begin
                        r_idx <= '0;
                        r_st  <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + H_BITS'(1);
                    end
                end
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_op         <= i_req.op;
                        r_cx         <= i_req.center_x;
                        r_cy         <= i_req.center_y;
                        r_a          <= i_req.semi_a;
                        r_b          <= i_req.semi_b;
                        r_px         <= i_req.point_x;
                        r_py         <= i_req.point_y;
                        r_top        <= acc_top;
                        r_bot        <= acc_bot;
                        r_res_inside <= 1'b0;
                        r_res_outer  <= 1'b0;
                        r_res_hole   <= 1'b0;
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_have_old   <= 1'b0;
                        r_sv         <= 1'b0;
                        case (i_req.op)
                            OP_QUERY: begin
                                r_st <= (i_req.point_y < eff_h) ? ST_QRD : ST_FIN;
                            end
                            OP_DEFAULTS: begin
                                r_st <= (eff_h != '0) ? ST_DEF : ST_FIN;
                            end
                            OP_OUTER, OP_INNER: begin
                                r_st <= (i_req.semi_a != '0 && i_req.semi_b != '0 &&
                                         eff_h != '0) ? ST_SCAN : ST_FIN;
                            end
                            default: begin
                                r_st <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_QRD: begin
                    r_st <= ST_QEV;
                end
                ST_QEV: begin
                    r_res_outer  <= q_outer;
                    r_res_hole   <= q_hole;
                    r_res_inside <= ({1'b0, r_px} < eff_w) && q_outer && !q_hole;
                    r_st         <= ST_FIN;
                end
                ST_DEF: begin
                    if (last_row) begin
                        r_st <= ST_FIN;
                    end else begin
                        r_idx <= r_idx + H_BITS'(1);
                    end
                end
                ST_SCAN: begin
                    // reads issue back to back; data arrives in the cycle after its address
                    r_sv   <= (r_idx < eff_h);
                    r_srow <= r_idx[ROW_BITS-1:0];
                    if (r_idx < eff_h) begin
                        r_idx <= r_idx + H_BITS'(1);
                    end
                    if (r_sv) begin
                        if (rd.lo != '0) begin
                            r_found <= 1'b1;
                        end
                        if (rd.li != '0) begin
                            if (!r_have_old) begin
                                r_old_top <= r_srow;
                            end
                            r_have_old <= 1'b1;
                            r_old_bot  <= r_srow;
                        end
                    end
                    if (!(r_idx < eff_h) && !r_sv) begin
                        r_idx <= '0;
                        r_st  <= ST_PRD;
                    end
                end
                ST_PRD: begin
                    r_st <= ST_PEV;
                end
                ST_PEV: begin
                    r_row <= rd;
                    if (span_cls) begin
                        r_st <= ST_PSPAN;
                    end else if (last_row) begin
                        r_st <= ST_FIN;
                    end else begin
                        r_idx <= r_idx + H_BITS'(1);
                        r_st  <= ST_PRD;
                    end
                end
                ST_PSPAN: begin
                    if (span_rsp.done) begin
                        if (last_row) begin
                            r_st <= ST_FIN;
                        end else begin
                            r_idx <= r_idx + H_BITS'(1);
                            r_st  <= ST_PRD;
                        end
                    end
                end
                ST_FIN: begin
                    // hold until the result register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= r_res_inside;
                        r_out_outer  <= r_res_outer;
                        r_out_hole   <= r_res_hole;
                        r_st         <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: tb/sv/elliptic_region_mask_table_core_tb.sv
// Testbench for elliptic_region_mask_table_core: random and directed table operations,
// with a scoreboard that predicts every result flag. Depends on erm_pkg, erm_in_if and
// erm_out_if from the RTL.
module elliptic_region_mask_table_core_tb;
    import erm_pkg::*;

    typedef struct {
        logic [1:0]            op;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
    } t_mask_op;

    typedef struct {
        logic usable;
        logic outer;
        logic hole;
        logic done;
    } t_mask_flags;

    class mask_scoreboard;
        logic [COORD_BITS-1:0] lo_t[MAX_ROWS];
        logic [COORD_BITS-1:0] li_t[MAX_ROWS];
        logic [COORD_BITS-1:0] ri_t[MAX_ROWS];
        logic [COORD_BITS-1:0] ro_t[MAX_ROWS];
        int unsigned width_reg;
        int unsigned height_reg;
        t_mask_flags pending_flags[$];
        int errors;

        function new();
            for (int i = 0; i < MAX_ROWS; i++) begin
                lo_t[i] = '0; li_t[i] = '0; ri_t[i] = '0; ro_t[i] = '0;
            end
            width_reg = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
            if (idx == CFG_IMAGE_WIDTH) width_reg = d;
            else height_reg = d[H_BITS-1:0];
        endfunction

        function longint frame_w();
            longint w;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > (1 << COORD_BITS)) w = 1 << COORD_BITS;
            return w;
        endfunction

        function longint rows_used();
            return (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
        endfunction

        function longint floor_root(longint v);
            longint r;
            r = 0;
            for (int k = 12; k >= 0; k--)
                if ((r | (longint'(1) << k)) * (r | (longint'(1) << k)) <= v)
                    r = r | (longint'(1) << k);
            return r;
        endfunction

        // Edges of the ellipse on one row, worked out in fixed point with FRAC_BITS fraction bits
        function void edges(longint row, longint cx, longint cy, longint a, longint b,
                            longint w, output longint x1, output longint x2);
            longint d, dd, bb, one, r, q, span, lfix, rfix;
            d = row - cy;
            dd = d * d;
            bb = b * b;
            one = longint'(1) << FRAC_BITS;
            if (dd >= bb) begin
                x1 = cx;
                x2 = cx;
                return;
            end
            r = (dd << FRAC_BITS) / bb;
            q = floor_root((one - r) << FRAC_BITS);
            span = a * q + (one >> 1);
            lfix = (cx << FRAC_BITS) - span;
            rfix = (cx << FRAC_BITS) + span;
            x1 = (lfix < one) ? 1 : (lfix >> FRAC_BITS);
            x2 = (rfix >= ((w - 1) << FRAC_BITS)) ? w - 2 : cx + (span >> FRAC_BITS);
        endfunction

        function void narrow_outer(longint cx, longint cy, longint a, longint b);
            longint w, h, top, bottom, x1, x2;
            bit any;
            w = frame_w();
            h = rows_used();
            any = 0;
            for (int i = 0; i < h; i++) if (lo_t[i] != 0) any = 1;
            if (!any) for (int i = 0; i < h; i++) ro_t[i] = COORD_BITS'(w - 1);
            top = (cy - b < 0) ? 0 : cy - b;
            for (longint i = 0; i <= top && i < h; i++) begin
                lo_t[i] = '0; ro_t[i] = '0;
            end
            bottom = (cy + b >= h) ? h - 1 : cy + b;
            for (longint i = top + 1; i <= bottom; i++) begin
                edges(i, cx, cy, a, b, w, x1, x2);
                if (lo_t[i] < x1 && ro_t[i] > x1) lo_t[i] = COORD_BITS'(x1);
                if (ro_t[i] > x2 && x2 > lo_t[i]) ro_t[i] = COORD_BITS'(x2);
            end
            for (longint i = bottom + 1; i < h; i++) begin
                lo_t[i] = '0; ro_t[i] = '0;
            end
        endfunction

        function void widen_hole(longint cx, longint cy, longint a, longint b);
            longint w, h, nt, nb, ot, ob, ut, ub, x1, x2, lo, ro, li, ri;
            w = frame_w();
            h = rows_used();
            nt = (cy - b < 0) ? 0 : cy - b;
            nb = (cy + b > h - 1) ? h - 1 : cy + b;
            ot = -1;
            ob = -1;
            for (int i = 0; i < h; i++)
                if (li_t[i] != 0) begin
                    if (ot < 0) ot = i;
                    ob = i;
                end
            ut = nt;
            ub = nb;
            if (ot >= 0) begin
                if (ot < ut) ut = ot;
                if (ob > ub) ub = ob;
            end
            for (longint i = 0; i < ut && i < h; i++) begin
                li_t[i] = '0; ri_t[i] = '0;
            end
            for (longint i = nt; i <= nb; i++) begin
                lo = lo_t[i]; ro = ro_t[i]; li = li_t[i]; ri = ri_t[i];
                edges(i, cx, cy, a, b, w, x1, x2);
                if (x1 >= lo && x1 < ro && (li == 0 || x1 < li)) li_t[i] = COORD_BITS'(x1);
                if (x2 <= ro && (ri == 0 || x2 > ri)) ri_t[i] = COORD_BITS'(x2);
            end
            for (longint i = ub + 1; i < h; i++) begin
                li_t[i] = '0; ri_t[i] = '0;
            end
        endfunction

        function void note_request(t_mask_op t);
            t_mask_flags f;
            longint px, py;
            f = '{0, 0, 0, 1};
            px = t.px;
            py = t.py;
            case (t.op)
                OP_OUTER: begin
                    if (t.a != 0 && t.b != 0) narrow_outer(t.cx, t.cy, t.a, t.b);
                end
                OP_INNER: begin
                    if (t.a != 0 && t.b != 0) widen_hole(t.cx, t.cy, t.a, t.b);
                end
                OP_DEFAULTS: begin
                    for (int i = 0; i < rows_used(); i++) begin
                        lo_t[i] = COORD_BITS'(1);
                        ro_t[i] = COORD_BITS'(frame_w() - 2);
                        li_t[i] = '0;
                        ri_t[i] = '0;
                    end
                end
                default: begin
                    if (py < rows_used()) begin
                        f.outer = (px >= lo_t[py] && px <= ro_t[py]);
                        f.hole = (px > li_t[py] && px < ri_t[py]);
                        f.usable = (px < frame_w()) && f.outer && !f.hole;
                    end
                end
            endcase
            pending_flags.push_back(f);
        endfunction

        function void check_result(t_mask_flags got);
            t_mask_flags exp_f;
            if (pending_flags.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            exp_f = pending_flags.pop_front();
            if (got.usable !== exp_f.usable) begin
                $error("inside_res: expected %0b, got %0b", exp_f.usable, got.usable);
                errors++;
            end
            if (got.outer !== exp_f.outer) begin
                $error("in_outer: expected %0b, got %0b", exp_f.outer, got.outer);
                errors++;
            end
            if (got.hole !== exp_f.hole) begin
                $error("in_hole: expected %0b, got %0b", exp_f.hole, got.hole);
                errors++;
            end
            if (got.done !== exp_f.done) begin
                $error("done_res: expected %0b, got %0b", exp_f.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    erm_in_if req_if();
    erm_out_if rsp_if();

    mask_scoreboard board = new();
    int burst_left = 0;

    elliptic_region_mask_table_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.op = OP_QUERY;
        req_if.center_x = '0;
        req_if.center_y = '0;
        req_if.semi_a = '0;
        req_if.semi_b = '0;
        req_if.point_x = '0;
        req_if.point_y = '0;
        rsp_if.ready = 1'b0;
    end

    // Result side: stall on a pattern whose mode is picked at random
    initial begin
        int cyc;
        int mode;
        t_mask_flags got;
        cyc = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: rsp_if.ready = 1'b1;
                1: rsp_if.ready = 1'($urandom_range(0, 1));
                2: rsp_if.ready = ($urandom_range(0, 3) == 0);
                default: rsp_if.ready = ((cyc / 5) % 2 == 0);
            endcase
            cyc++;
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.inside_res, rsp_if.in_outer, rsp_if.in_hole, rsp_if.done_res};
                board.check_result(got);
            end
        end
    end

    task automatic send_op(t_mask_op t);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            // drop valid for a random gap, which may be zero, then start a new burst
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_if.valid = 1'b1;
        req_if.op = t.op;
        req_if.center_x = t.cx;
        req_if.center_y = t.cy;
        req_if.semi_a = t.a;
        req_if.semi_b = t.b;
        req_if.point_x = t.px;
        req_if.point_y = t.py;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(t);
        burst_left--;
    endtask

    task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        @(negedge i_clk);
        req_if.valid = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = d;
        @(posedge i_clk);
        board.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        // drop valid so that the last transaction is not taken twice
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (board.pending_flags.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic t_mask_op make_op(logic [1:0] op, int cx, int cy, int a, int b,
                                         int px, int py);
        t_mask_op t;
        t.op = op;
        t.cx = COORD_BITS'(cx);
        t.cy = COORD_BITS'(cy);
        t.a = COORD_BITS'(a);
        t.b = COORD_BITS'(b);
        t.px = COORD_BITS'(px);
        t.py = COORD_BITS'(py);
        return t;
    endfunction

    function automatic t_mask_op random_op();
        t_mask_op t;
        int pick, h, w;
        h = int'(board.rows_used());
        w = int'(board.frame_w());
        pick = $urandom_range(0, 99);
        t.op = (pick < 55) ? OP_QUERY : (pick < 73) ? OP_OUTER : (pick < 90) ? OP_INNER
                                                                           : OP_DEFAULTS;
        if ($urandom_range(0, 9) == 0) begin
            // raw noise across every bit of every coordinate and axis field
            t.cx = COORD_BITS'($urandom);
            t.cy = COORD_BITS'($urandom);
            t.a = COORD_BITS'($urandom);
            t.b = COORD_BITS'($urandom);
            t.px = COORD_BITS'($urandom);
            t.py = COORD_BITS'($urandom);
        end else begin
            t.cx = COORD_BITS'($urandom_range(0, (w > 1023) ? 1023 : w));
            t.cy = COORD_BITS'($urandom_range(0, h + 4));
            t.a = ($urandom_range(0, 15) == 0) ? '0 : COORD_BITS'($urandom_range(1, w / 2 + 2));
            t.b = ($urandom_range(0, 15) == 0) ? '0 : COORD_BITS'($urandom_range(1, h / 2 + 3));
            t.px = COORD_BITS'($urandom_range(0, (w + 2 > 1023) ? 1023 : w + 2));
            t.py = COORD_BITS'($urandom_range(0, h + 1));
        end
        return t;
    endfunction

    initial begin
        int w_pick, h_val, n_items;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: cleared table, zero semi-axes, first outer, defaults, union of holes
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 0, 0));
        send_op(make_op(OP_QUERY, 1023, 1023, 1023, 1023, 1023, 289));
        send_op(make_op(OP_OUTER, 180, 140, 0, 50, 0, 0));
        send_op(make_op(OP_INNER, 180, 140, 50, 0, 0, 0));
        send_op(make_op(OP_OUTER, 180, 140, 170, 150, 0, 0));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 180, 140));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 359, 0));
        send_op(make_op(OP_OUTER, 180, 20, 60, 30, 0, 0));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 180, 20));
        send_op(make_op(OP_DEFAULTS, 0, 0, 0, 0, 0, 0));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 1, 100));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 358, 100));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 359, 290));
        send_op(make_op(OP_INNER, 180, 140, 40, 30, 0, 0));
        send_op(make_op(OP_INNER, 200, 180, 60, 20, 0, 0));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 180, 140));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 1023, 140));
        send_op(make_op(OP_OUTER, 1023, 1023, 1023, 1023, 0, 0));
        send_op(make_op(OP_INNER, 0, 0, 1023, 1023, 0, 0));
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 1000, 289));
        send_op(make_op(OP_DEFAULTS, 0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 13; ph++) begin
            wait_idle();
            w_pick = $urandom_range(0, 9);
            case (w_pick)
                0: write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(0));
                1: write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
                2: write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(1024));
                3: write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(2047));
                4: write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'($urandom_range(1, 2)));
                default: write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'($urandom_range(3, 1024)));
            endcase
            // keep most heights small so that applies stay short
            if (ph == 3) h_val = 1023;
            else if (ph == 7) h_val = 512;
            else if (ph == 9) h_val = 0;
            else h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1023)
                                                     : $urandom_range(1, 24);
            write_cfg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h_val));
            n_items = (board.rows_used() > 64) ? 20 : 150;
            if ($urandom_range(0, 1)) send_op(make_op(OP_DEFAULTS, 0, 0, 0, 0, 0, 0));
            for (int k = 0; k < n_items; k++) send_op(random_op());
        end
        // return to wide extremes once more
        wait_idle();
        write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(1024));
        write_cfg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(16));
        for (int k = 0; k < 100; k++) send_op(random_op());

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (board.pending_flags.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #400000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: sim.f
rtl/erm_pkg.sv
rtl/erm_in_if.sv
rtl/erm_out_if.sv
rtl/erm_ram.sv
rtl/erm_span.sv
rtl/elliptic_region_mask_table_core.sv
tb/sv/elliptic_region_mask_table_core_tb.sv
